### rtl/pn_pkg.sv
package pn_pkg;

	localparam int SAMPLE_W          = 24;
	localparam int CNT_W             = 2;
	localparam int CHANNELS_DEF      = 2;
	localparam int FRACTION_BITS_DEF = 22;
	localparam int CHANNELS_RESET    = 2;
	localparam int SAMPLE_MAX        = 8388607;
	localparam int SAMPLE_MIN_MAG    = 8388608;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_APPLY   = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic [SAMPLE_W-1:0] pn_magnitude(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] m;
		m = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
		return m;
	endfunction

endpackage

### rtl/pn_lane.sv
module pn_lane import pn_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [SAMPLE_W-1:0]        sample,
	input  logic [2*FRACTION_BITS:0]   gain,
	input  logic                       bypass,
	output logic [SAMPLE_W-1:0]        mag,
	output logic [SAMPLE_W-1:0]        result
);

	localparam int GW = 2*FRACTION_BITS + 1;
	localparam int GL = GW / 2;
	localparam int GH = GW - GL;
	localparam int PW = SAMPLE_W + GW;
	localparam int QW = PW - FRACTION_BITS;

	logic [SAMPLE_W-1:0]    smp_s1, smp_s2;
	logic                   byp_s1, byp_s2;
	logic                   neg_s1, neg_s2;
	logic [SAMPLE_W+GL-1:0] pp_lo_s1;
	logic [SAMPLE_W+GH-1:0] pp_hi_s1;
	logic [PW-1:0]          prod_s2;

	logic [QW-1:0]          q;
	logic [QW:0]            qn;
	logic                   frac_nz;
	logic [SAMPLE_W-1:0]    scaled;

	assign mag = pn_magnitude(sample);

	// partial products on the two halves of the gain
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1   <= sample;
			byp_s1   <= bypass;
			neg_s1   <= sample[SAMPLE_W-1];
			pp_lo_s1 <= (SAMPLE_W+GL)'(mag) * (SAMPLE_W+GL)'(gain[GL-1:0]);
			pp_hi_s1 <= (SAMPLE_W+GH)'(mag) * (SAMPLE_W+GH)'(gain[GW-1:GL]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s2  <= smp_s1;
			byp_s2  <= byp_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= (PW'(pp_hi_s1) << GL) + PW'(pp_lo_s1);
		end
	end

	// floor toward minus infinity: round magnitude up for negative samples
	always_comb begin
		q       = prod_s2[PW-1:FRACTION_BITS];
		frac_nz = |prod_s2[FRACTION_BITS-1:0];
		qn      = {1'b0, q} + (QW+1)'(neg_s2 & frac_nz);
		if (neg_s2) begin
			if (qn > (QW+1)'(SAMPLE_MIN_MAG))
				scaled = {1'b1, {(SAMPLE_W-1){1'b0}}};
			else
				scaled = ~qn[SAMPLE_W-1:0] + 1'b1;
		end else begin
			if (q > QW'(SAMPLE_MAX))
				scaled = {1'b0, {(SAMPLE_W-1){1'b1}}};
			else
				scaled = q[SAMPLE_W-1:0];
		end
	end

	assign result = byp_s2 ? smp_s2 : scaled;

endmodule

### rtl/pn_div.sv
module pn_div import pn_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SAMPLE_W-1:0]        divisor,
	output div_status_t                status,
	output logic [2*FRACTION_BITS:0]   quotient
);

	localparam int GW = 2*FRACTION_BITS + 1;
	localparam int CW = $clog2(GW);

	logic                busy_q, done_q;
	logic [CW-1:0]       cnt_q;
	logic [SAMPLE_W-1:0] rem_q, dvs_q;
	logic [GW-1:0]       quo_q;

	logic [SAMPLE_W:0]   r2;
	logic                ge;

	// dividend is 2^(2*frac): its only set bit enters on the first step
	always_comb begin
		r2 = {rem_q, (cnt_q == '0)};
		ge = r2 >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(GW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? SAMPLE_W'(r2 - {1'b0, dvs_q}) : r2[SAMPLE_W-1:0];
			quo_q <= {quo_q[GW-2:0], ge};
		end
	end

	assign status.busy = busy_q | done_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

### rtl/peak_normalize.sv
// latency: an accepted apply word moves through the s1 and s2 registers into m_tvalid
// throughput: one word per cycle unless the output is held or the divider is busy
// a measure word marked last with a usable peak stalls input while the
//   bit-serial divider forms the gain
// reset: asynchronous, clears peak and gain, enters pass-through, channel count 2
module peak_normalize import pn_pkg::*; #(
	parameter int CHANNELS      = CHANNELS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2*SAMPLE_W-1:0] s_tdata,   // sample_0, sample_1
	input  logic [1:0]            s_tuser,   // operation, first_frame
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [2*SAMPLE_W-1:0] m_tdata,   // out_sample_0, out_sample_1
	output logic [0:0]            m_tuser,   // normalized
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data
);

	localparam int  GW     = 2*FRACTION_BITS + 1;
	localparam bit  HAS_CH1 = CHANNELS > 1;
	localparam int  CMPW   = (FRACTION_BITS + 1 > SAMPLE_W) ? FRACTION_BITS + 1 : SAMPLE_W;
	localparam logic [CMPW-1:0] ONE_LVL = CMPW'(1) << FRACTION_BITS;

	logic [CNT_W-1:0]    chan_cnt_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [GW-1:0]       gain_q;
	logic                bypass_q;

	logic                v_s1, v_s2;
	logic                last_s1, last_s2, byp_s1, byp_s2, st_s1, st_s2;

	logic                en, acc, is_apply, stereo, peak_bad, div_start;
	logic [SAMPLE_W-1:0] mag [CHANNELS];
	logic [SAMPLE_W-1:0] res [CHANNELS];
	logic [SAMPLE_W-1:0] mag1, peak_base, peak_next, ch1_out;
	logic [GW-1:0]       quotient;
	div_status_t         div_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chan_cnt_q <= CNT_W'(CHANNELS_RESET);
		else if (cfg_valid && cfg_ready)
			chan_cnt_q <= cfg_data;
	end

	assign stereo   = HAS_CH1 && (chan_cnt_q >= CNT_W'(2));
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en && !div_st.busy;
	assign acc      = s_tvalid && s_tready;
	assign is_apply = s_tuser[0] == OP_APPLY;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		pn_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
			.clk    (clk),
			.en     (en),
			.sample (s_tdata[c*SAMPLE_W +: SAMPLE_W]),
			.gain   (gain_q),
			.bypass (bypass_q),
			.mag    (mag[c]),
			.result (res[c])
		);
	end

	// merge the lane magnitudes into the running peak
	always_comb begin
		mag1      = (HAS_CH1 && stereo) ? mag[CHANNELS-1] : '0;
		peak_base = s_tuser[1] ? '0 : peak_q;
		peak_next = peak_base;
		if (mag[0] > peak_next)
			peak_next = mag[0];
		if (mag1 > peak_next)
			peak_next = mag1;
		peak_bad  = (peak_next == '0) || (CMPW'(peak_next) > ONE_LVL);
		div_start = acc && !is_apply && s_tlast && !peak_bad;
	end

	pn_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (peak_next),
		.status   (div_st),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= '0;
			gain_q   <= '0;
			bypass_q <= 1'b1;
		end else begin
			if (acc && !is_apply) begin
				peak_q <= peak_next;
				if (s_tlast && peak_bad) begin
					bypass_q <= 1'b1;
					gain_q   <= '0;
				end
			end
			if (div_st.done) begin
				bypass_q <= 1'b0;
				gain_q   <= quotient;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= acc && is_apply;
			v_s2     <= v_s1;
			m_tvalid <= v_s2;
		end
	end

	assign ch1_out = (HAS_CH1 && st_s2) ? res[CHANNELS-1] : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= s_tlast;
			byp_s1  <= bypass_q;
			st_s1   <= stereo;
			last_s2 <= last_s1;
			byp_s2  <= byp_s1;
			st_s2   <= st_s1;
			if (v_s2) begin
				m_tdata <= {ch1_out, res[0]};
				m_tuser <= ~byp_s2;
				m_tlast <= last_s2;
			end
		end
	end

endmodule

### rtl/pn_checker.sv
module pn_checker import pn_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [1:0]            s_tuser,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [2*SAMPLE_W-1:0] m_tdata,
	input logic [0:0]            m_tuser,
	input logic                  m_tlast,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CNT_W-1:0]      cfg_data
);

	logic mono_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mono_q <= 1'b0;
		else if (cfg_valid && cfg_ready)
			mono_q <= cfg_data < CNT_W'(2);
	end

	// input only stalls behind a held output or after a pass-ending measure word
	a_tready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> (m_tvalid && !m_tready) ||
			$past(m_tvalid && !m_tready) ||
			$past(s_tvalid && s_tready && s_tuser[0] == OP_MEASURE && s_tlast))
		else $error("input stalled without cause");

	a_mono_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mono_q |-> m_tdata[2*SAMPLE_W-1:SAMPLE_W] == '0)
		else $error("second channel not zero in mono");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

endmodule

bind peak_normalize pn_checker u_chk (.*);

### tb/sv/peak_normalize_tb.sv
`timescale 1ns / 100ps

module peak_normalize_tb;
	import pn_pkg::*;

	localparam int FRAC          = FRACTION_BITS_DEF;
	localparam int SETTLE_CYCLES = 60;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_WORDS   = 310;

	typedef struct packed {
		logic                 op;
		logic signed [23:0]   s0;
		logic signed [23:0]   s1;
		logic                 first;
		logic                 last;
		logic                 drain;
	} frame_in_t;

	typedef struct packed {
		logic signed [23:0]   o0;
		logic signed [23:0]   o1;
		logic                 norm;
		logic                 eor;
	} frame_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [2*SAMPLE_W-1:0] s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [2*SAMPLE_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CNT_W-1:0]      cfg_data = '0;

	// predictor state
	logic [1:0]  chan_setting = 2'd2;
	logic [23:0] peak_mag = '0;
	logic [44:0] gain_q = '0;
	logic        passthru = 1'b1;

	frame_in_t  pending_words[$];
	frame_out_t expected_frames[$];
	frame_in_t  cur_word;

	int send_idle = 0;
	int recv_idle = 0;
	int error_count = 0;
	int measure_words = 0;
	int apply_words = 0;
	int checked_words = 0;
	int normalized_words = 0;
	int stall_cycles = 0;

	peak_normalize uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [23:0] abs_sample(input logic signed [23:0] s);
		int v;
		v = int'(s);
		if (v < 0)
			v = -v;
		return v[23:0];
	endfunction

	// floor(s * gain / 2^FRAC) with saturation to the sample range
	function automatic logic signed [23:0] scale_sample(input logic signed [23:0] s);
		logic [69:0] prod;
		logic [69:0] q;
		prod = 70'(abs_sample(s)) * 70'(gain_q);
		q = prod >> FRAC;
		if (s[23] && prod[FRAC-1:0] != '0)
			q = q + 70'd1;
		if (s[23]) begin
			if (q > 70'd8388608)
				return 24'h800000;
			return ~q[23:0] + 24'd1;
		end
		if (q > 70'(SAMPLE_MAX))
			return 24'h7FFFFF;
		return q[23:0];
	endfunction

	function automatic void predict_frame(input frame_in_t w);
		int         nch;
		logic [23:0] m;
		frame_out_t r;
		nch = int'(chan_setting);
		if (nch < 1)
			nch = 1;
		if (nch > CHANNELS_DEF)
			nch = CHANNELS_DEF;
		if (w.op == OP_MEASURE) begin
			if (w.first)
				peak_mag = '0;
			m = abs_sample(w.s0);
			if (m > peak_mag)
				peak_mag = m;
			if (nch >= 2) begin
				m = abs_sample(w.s1);
				if (m > peak_mag)
					peak_mag = m;
			end
			if (w.last) begin
				if (peak_mag == '0 || 25'(peak_mag) > (25'd1 << FRAC)) begin
					passthru = 1'b1;
					gain_q = '0;
				end else begin
					passthru = 1'b0;
					gain_q = (45'd1 << (2 * FRAC)) / 45'(peak_mag);
				end
			end
		end else begin
			r.o0 = passthru ? w.s0 : scale_sample(w.s0);
			r.o1 = '0;
			if (nch >= 2)
				r.o1 = passthru ? w.s1 : scale_sample(w.s1);
			r.norm = ~passthru;
			r.eor = w.last;
			expected_frames.push_back(r);
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_frame(cur_word);
				if (cur_word.op == OP_MEASURE)
					measure_words++;
				else
					apply_words++;
			end
			if (!s_tvalid || s_tready) begin
				// a drain word waits until every pending result has come back
				if (pending_words.size() != 0
						&& (!pending_words[0].drain || expected_frames.size() == 0)
						&& $urandom_range(0, 99) >= send_idle) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_word.s1, cur_word.s0};
					s_tuser <= {cur_word.first, cur_word.op};
					s_tlast <= cur_word.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		frame_out_t exp_w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				checked_words++;
				if (expected_frames.size() == 0) begin
					$error("unexpected result word: data %h user %b last %b",
						m_tdata, m_tuser, m_tlast);
					error_count++;
				end else begin
					exp_w = expected_frames.pop_front();
					if (exp_w.norm)
						normalized_words++;
					if (m_tdata[23:0] !== exp_w.o0) begin
						$error("out_sample_0: expected %0d, actual %0d",
							$signed(exp_w.o0), $signed(m_tdata[23:0]));
						error_count++;
					end
					if (m_tdata[47:24] !== exp_w.o1) begin
						$error("out_sample_1: expected %0d, actual %0d",
							$signed(exp_w.o1), $signed(m_tdata[47:24]));
						error_count++;
					end
					if (m_tuser[0] !== exp_w.norm) begin
						$error("normalized: expected %0b, actual %0b", exp_w.norm, m_tuser[0]);
						error_count++;
					end
					if (m_tlast !== exp_w.eor) begin
						$error("end_of_run: expected %0b, actual %0b", exp_w.eor, m_tlast);
						error_count++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("peak_normalize_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic push_word(input logic op, input logic [23:0] s0, input logic [23:0] s1,
			input logic first, input logic last);
		frame_in_t w;
		w.op = op;
		w.s0 = s0;
		w.s1 = s1;
		w.first = first;
		w.last = last;
		w.drain = ($urandom_range(0, 127) == 0);
		pending_words.push_back(w);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_words.size() != 0 || s_tvalid || expected_frames.size() != 0);
		// a measure word can still hold the divider busy
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// call at a rising edge
	task automatic write_channel_count(input logic [1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		chan_setting = v;
	endtask

	function automatic int pick_amp();
		case ($urandom_range(0, 5))
			0: return 8388608;
			1: return 4194304;
			2: return $urandom_range(1, 4194304);
			3: return $urandom_range(1, 1023);
			4: return $urandom_range(4194305, 8388608);
			default: return 0;
		endcase
	endfunction

	function automatic logic [23:0] rand_sample(input int amp);
		int v;
		if (amp == 0)
			return '0;
		case ($urandom_range(0, 9))
			0: v = amp;
			1: v = -amp;
			default: begin
				v = $urandom_range(0, 2 * amp);
				v = v - amp;
			end
		endcase
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[23:0];
	endfunction

	// mostly whole measure passes followed by apply runs, some noise and broken passes
	task automatic queue_random(input int n_words);
		int queued;
		int amp;
		int n_meas;
		int n_app;
		bit broken;
		queued = 0;
		while (queued < n_words) begin
			if ($urandom_range(0, 9) == 0) begin
				push_word(1'($urandom_range(0, 1)), 24'($urandom()), 24'($urandom()),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				queued++;
			end else begin
				amp = pick_amp();
				n_meas = $urandom_range(1, 6);
				broken = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < n_meas; k++)
					push_word(OP_MEASURE, rand_sample(amp), rand_sample(amp), k == 0,
						k == n_meas - 1 && !broken);
				n_app = $urandom_range(1, 8);
				for (int k = 0; k < n_app; k++) begin
					if ($urandom_range(0, 99) < 85)
						push_word(OP_APPLY, rand_sample(amp), rand_sample(amp),
							1'($urandom_range(0, 1)), k == n_app - 1);
					else
						push_word(OP_APPLY, rand_sample(8388608), rand_sample(8388608),
							1'($urandom_range(0, 1)), k == n_app - 1);
				end
				queued += n_meas + n_app;
			end
		end
	endtask

	initial begin
		int         send_pct[6];
		int         recv_pct[6];
		logic [1:0] chans[6];
		send_pct = '{33, 33, 73, 73, 0, 0};
		recv_pct = '{73, 73, 33, 33, 0, 0};
		chans = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_channel_count(2'd2);

		@(negedge clk);
		send_idle = 33;
		recv_idle = 73;
		// pass-through from reset, first mark on apply ignored
		push_word(OP_APPLY, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
		push_word(OP_APPLY, 24'h000000, 24'hFFFFFF, 1'b1, 1'b1);
		// both marks on one word, peak exactly 1.0
		push_word(OP_MEASURE, 24'h400000, 24'hE00000, 1'b1, 1'b1);
		push_word(OP_APPLY, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
		push_word(OP_APPLY, 24'h123456, 24'hEDCBAA, 1'b0, 1'b1);
		// peak 0.5, gain 2.0 drives the extremes into saturation
		push_word(OP_MEASURE, 24'h200000, 24'h000000, 1'b1, 1'b0);
		push_word(OP_MEASURE, 24'hFFFF9C, 24'h000005, 1'b0, 1'b1);
		push_word(OP_APPLY, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
		push_word(OP_APPLY, 24'hFFFFFF, 24'h000001, 1'b0, 1'b0);
		push_word(OP_APPLY, 24'hFFFFFD, 24'h003039, 1'b0, 1'b1);
		// zero peak
		push_word(OP_MEASURE, 24'h000000, 24'h000000, 1'b1, 1'b1);
		push_word(OP_APPLY, 24'h0ABCDE, 24'hF54322, 1'b0, 1'b1);
		// peak above 1.0
		push_word(OP_MEASURE, 24'h800000, 24'h000000, 1'b1, 1'b1);
		push_word(OP_APPLY, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
		// smallest peak, largest gain
		push_word(OP_MEASURE, 24'h000001, 24'h000000, 1'b1, 1'b1);
		push_word(OP_APPLY, 24'h000001, 24'h000002, 1'b0, 1'b0);
		push_word(OP_APPLY, 24'hFFFFFF, 24'hFFFFFE, 1'b0, 1'b1);
		// one lsb above 1.0
		push_word(OP_MEASURE, 24'h400001, 24'h000000, 1'b1, 1'b1);
		push_word(OP_APPLY, 24'h100000, 24'hF00000, 1'b0, 1'b1);
		// odd peak over two frames
		push_word(OP_MEASURE, 24'h2DC6C1, 24'h000000, 1'b1, 1'b0);
		push_word(OP_MEASURE, 24'h000000, 24'hFE1DBF, 1'b0, 1'b1);
		push_word(OP_APPLY, 24'h2DC6C1, 24'hD23940, 1'b0, 1'b0);
		push_word(OP_APPLY, 24'h155555, 24'hEAAAAB, 1'b0, 1'b1);
		pending_words[5].drain = 1'b1;
		wait_idle();

		write_channel_count(2'd1);
		@(negedge clk);
		// mono: second sample must not count toward the peak
		push_word(OP_MEASURE, 24'h0003E8, 24'h800000, 1'b1, 1'b1);
		push_word(OP_APPLY, 24'h0001F4, 24'h7FFFFF, 1'b0, 1'b1);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_channel_count(chans[p]);
			@(negedge clk);
			send_idle = send_pct[p];
			recv_idle = recv_pct[p];
			queue_random(PHASE_WORDS);
			pending_words[PHASE_WORDS / 2].drain = 1'b1;
		end
		wait_idle();

		$display("covered %0d measure and %0d apply words, channel counts 0 to 3, three idle mixes",
			measure_words, apply_words);
		$display("checked %0d result words, %0d of them normalized", checked_words,
			normalized_words);
		if (error_count == 0)
			$display("peak_normalize_tb: PASS");
		else
			$display("peak_normalize_tb: FAIL");
		$finish;
	end

endmodule
